// File: sv/lirf_pkg.sv
// shared constants for the lcp interval repeat finder
`default_nettype none

package lirf_pkg;

    // field widths
    localparam int LEN_W  = 7;
    localparam int POS_W  = 20;
    localparam int RANK_W = 20;
    localparam int OCC_W  = 21;

    // default stack depth limit on the prefix length
    localparam int MAX_DEPTH_DEF = 64;

endpackage

`default_nettype wire

// File: sv/lirf_ram.sv
// generic single write port ram with registered read
`default_nettype none

module lirf_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 65
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/lcp_interval_repeat_finder_core.sv
// Bottom-up lcp interval walker: one ranked suffix in, repeats out of popped levels.
// Steps per item: accept in idle, then a stack ram read and an evaluate step per popped
// level, a send of the final result when one is pending, and a write per pushed level;
// output stalls can hold the evaluate and send steps. The block takes no new item until
// it is through with the last one, as the sequencer walks the stack ram one level at a time.
// Reset: stack empty, rank zero, no result pending; the stack ram needs no clearing.
`default_nettype none

module lcp_interval_repeat_finder_core #(
    parameter int MAX_DEPTH = lirf_pkg::MAX_DEPTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       item_valid,
    output logic                            item_stall,
    input  wire logic [lirf_pkg::LEN_W-1:0] prefix_len,
    input  wire logic [lirf_pkg::POS_W-1:0] suffix_start,
    input  wire logic                       last_entry,
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output logic [lirf_pkg::OCC_W-1:0]      occurrences,
    output logic [lirf_pkg::LEN_W-1:0]      repeat_len,
    output logic [lirf_pkg::POS_W-1:0]      repeat_start,
    output logic                            run_end
);

    localparam int DEPTH  = MAX_DEPTH + 1;
    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(MAX_DEPTH + 2);
    localparam int RANK_W = lirf_pkg::RANK_W;
    localparam int POS_W  = lirf_pkg::POS_W;
    localparam int LEN_W  = lirf_pkg::LEN_W;
    localparam int OCC_W  = lirf_pkg::OCC_W;
    localparam int ENT_W  = RANK_W + POS_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_POP   = 5'b00010,
        S_EVAL  = 5'b00100,
        S_FLUSH = 5'b01000,
        S_PUSH  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;     // open levels, top level is count - 1
    logic [RANK_W-1:0]  rank_reg, rank_next;
    logic [CNT_W-1:0]   target_reg, target_next;
    logic [POS_W-1:0]   start_reg, start_next;
    logic               last_reg, last_next;

    // pending result, waiting to learn whether it ends the run
    logic               pend_valid_reg, pend_valid_next;
    logic [OCC_W-1:0]   pend_occ_reg, pend_occ_next;
    logic [LEN_W-1:0]   pend_len_reg, pend_len_next;
    logic [POS_W-1:0]   pend_pos_reg, pend_pos_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [OCC_W-1:0]   out_occ_reg, out_occ_next;
    logic [LEN_W-1:0]   out_len_reg, out_len_next;
    logic [POS_W-1:0]   out_pos_reg, out_pos_next;
    logic               out_end_reg, out_end_next;

    logic               ram_we;
    logic               ram_re;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic [ENT_W-1:0]   ram_rdata;
    logic [RANK_W-1:0]  rd_rank;
    logic [POS_W-1:0]   rd_start;
    logic [RANK_W-1:0]  rank_diff;
    logic [CNT_W-1:0]   target_p1;
    logic [CNT_W-1:0]   in_target;
    logic               out_free;
    logic               qualifies;

    // level stack: opening rank and suffix start per level
    lirf_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({rank_reg, start_reg}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_rank   = ram_rdata[ENT_W-1:POS_W];
    assign rd_start  = ram_rdata[POS_W-1:0];
    assign rank_diff = rank_reg - rd_rank;
    assign target_p1 = target_reg + CNT_W'(1);
    assign ram_raddr = AW'(count_reg - CNT_W'(1));
    assign ram_waddr = AW'(count_reg);
    assign out_free  = !out_valid_reg || !result_stall;
    assign qualifies = (rank_diff != '0) && (count_reg > CNT_W'(2));

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign occurrences  = out_occ_reg;
    assign repeat_len   = out_len_reg;
    assign repeat_start = out_pos_reg;
    assign run_end      = out_end_reg;

    // clamp incoming prefix length to the stack depth
    always_comb
    begin
        if (int'(prefix_len) > MAX_DEPTH)
        begin
            in_target = CNT_W'(MAX_DEPTH);
        end
        else
        begin
            in_target = CNT_W'(prefix_len);
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rank_next       = rank_reg;
        target_next     = target_reg;
        start_next      = start_reg;
        last_next       = last_reg;
        pend_valid_next = pend_valid_reg;
        pend_occ_next   = pend_occ_reg;
        pend_len_next   = pend_len_reg;
        pend_pos_next   = pend_pos_reg;
        out_valid_next  = out_valid_reg && result_stall;
        out_occ_next    = out_occ_reg;
        out_len_next    = out_len_reg;
        out_pos_next    = out_pos_reg;
        out_end_next    = out_end_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    target_next = in_target;
                    start_next  = suffix_start;
                    last_next   = last_entry;
                    state_next  = S_POP;
                end
            end
            S_POP:
            begin
                if (count_reg > target_p1)
                begin
                    ram_re     = 1'b1;
                    state_next = S_EVAL;
                end
                else if (pend_valid_reg)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_EVAL:
            begin
                // a new result pushes the pending one out as a non-final transfer
                if (qualifies && pend_valid_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_occ_next   = pend_occ_reg;
                        out_len_next   = pend_len_reg;
                        out_pos_next   = pend_pos_reg;
                        out_end_next   = 1'b0;
                        pend_occ_next  = OCC_W'(rank_diff) + OCC_W'(1);
                        pend_len_next  = LEN_W'(count_reg - CNT_W'(1));
                        pend_pos_next  = rd_start;
                        count_next     = count_reg - CNT_W'(1);
                        state_next     = S_POP;
                    end
                end
                else
                begin
                    if (qualifies)
                    begin
                        pend_valid_next = 1'b1;
                        pend_occ_next   = OCC_W'(rank_diff) + OCC_W'(1);
                        pend_len_next   = LEN_W'(count_reg - CNT_W'(1));
                        pend_pos_next   = rd_start;
                    end
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_POP;
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_occ_next    = pend_occ_reg;
                    out_len_next    = pend_len_reg;
                    out_pos_next    = pend_pos_reg;
                    out_end_next    = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (count_reg < target_p1)
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    if (last_reg)
                    begin
                        count_next = '0;
                        rank_next  = '0;
                    end
                    else
                    begin
                        rank_next = rank_reg + RANK_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            rank_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rank_reg       <= rank_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        target_reg   <= target_next;
        start_reg    <= start_next;
        last_reg     <= last_next;
        pend_occ_reg <= pend_occ_next;
        pend_len_reg <= pend_len_next;
        pend_pos_reg <= pend_pos_next;
        out_occ_reg  <= out_occ_next;
        out_len_reg  <= out_len_next;
        out_pos_reg  <= out_pos_next;
        out_end_reg  <= out_end_next;
    end

    // no result may be left pending once the item is done
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("result left pending at end of item");

    // a pop read needs a non-empty stack
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (count_reg != '0))
        else $error("pop read from empty stack");

    // pushes stay inside the stack
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (int'(count_reg) <= MAX_DEPTH))
        else $error("push beyond stack depth");

    // a flush that goes out marks the end of the run
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH) && out_free |=> result_valid && run_end && !pend_valid_reg)
        else $error("final result not sent with run end");

endmodule

`default_nettype wire

// File: bench/tb_lcp_interval_repeat_finder_core.sv
// testbench for the lcp interval repeat finder core: random and directed stimulus with a predictor
`timescale 1ns / 1ps

module tb_lcp_interval_repeat_finder_core;

    localparam int LEN_W          = lirf_pkg::LEN_W;
    localparam int POS_W          = lirf_pkg::POS_W;
    localparam int RANK_W         = lirf_pkg::RANK_W;
    localparam int OCC_W          = lirf_pkg::OCC_W;
    localparam int DEPTH          = lirf_pkg::MAX_DEPTH_DEF;
    localparam int ITEM_TARGET    = 430;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_LIMIT    = 40;

    // one ranked suffix as offered to the block
    typedef struct packed {
        logic [LEN_W-1:0] plen;
        logic [POS_W-1:0] start;
        logic             last;
        logic             drain;
    } suffix_entry_t;

    // one repeat as reported by the block
    typedef struct packed {
        logic [OCC_W-1:0] occ;
        logic [LEN_W-1:0] len;
        logic [POS_W-1:0] pos;
        logic             fin;
    } repeat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic             item_valid = 1'b0;
    logic             item_stall;
    logic [LEN_W-1:0] prefix_len = '0;
    logic [POS_W-1:0] suffix_start = '0;
    logic             last_entry = 1'b0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    logic [OCC_W-1:0] occurrences;
    logic [LEN_W-1:0] repeat_len;
    logic [POS_W-1:0] repeat_start;
    logic             run_end;

    suffix_entry_t pending_items[$];
    repeat_t       repeats_due[$];
    suffix_entry_t next_item;
    repeat_t       due;

    // predictor state: open levels of the lcp stack
    logic [RANK_W-1:0] open_rank [0:DEPTH];
    logic [POS_W-1:0]  open_start [0:DEPTH];
    int                top_lvl = -1;
    logic [RANK_W-1:0] cur_rank = '0;

    logic in_xfer_q = 1'b0;
    int   items_in = 0;
    int   err_count = 0;
    int   idle_cycles = 0;
    int   cyc_count = 0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   holdoff_left = 0;
    logic holdoff_done = 1'b0;

    lcp_interval_repeat_finder_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .prefix_len   (prefix_len),
        .suffix_start (suffix_start),
        .last_entry   (last_entry),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .occurrences  (occurrences),
        .repeat_len   (repeat_len),
        .repeat_start (repeat_start),
        .run_end      (run_end)
    );

    // clock, period 8 ns
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic note_mismatch(input string what, input longint got, input longint want);
        if (err_count < PRINT_LIMIT)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic add_entry(input int plen, input int start, input bit last, input bit drain);
        suffix_entry_t e;
        e.plen  = plen[LEN_W-1:0];
        e.start = start[POS_W-1:0];
        e.last  = last;
        e.drain = drain;
        pending_items.push_back(e);
    endtask

    // pop closed levels into repeats, then open levels up to the new prefix length
    task automatic predict_repeats(input logic [LEN_W-1:0] plen, input logic [POS_W-1:0] start,
                                   input logic last);
        int                target;
        bit                have;
        repeat_t           held;
        logic [RANK_W-1:0] rank_gap;
        logic [OCC_W-1:0]  span;
        target = (plen > DEPTH) ? DEPTH : int'(plen);
        have = 1'b0;
        held = '0;
        while (top_lvl > target)
        begin
            rank_gap = cur_rank - open_rank[top_lvl];
            span = {1'b0, rank_gap} + 1'b1;
            if (span > 1 && top_lvl > 1)
            begin
                if (have)
                    repeats_due.push_back(held);
                held.occ = span;
                held.len = top_lvl[LEN_W-1:0];
                held.pos = open_start[top_lvl];
                held.fin = 1'b0;
                have = 1'b1;
            end
            top_lvl--;
        end
        if (have)
        begin
            held.fin = 1'b1;
            repeats_due.push_back(held);
        end
        while (top_lvl < target)
        begin
            top_lvl++;
            open_rank[top_lvl] = cur_rank;
            open_start[top_lvl] = start;
        end
        cur_rank = cur_rank + 1'b1;
        if (last)
        begin
            top_lvl = -1;
            cur_rank = '0;
        end
    endtask

    // monitor: check result transfers, predict on item transfers
    always @(posedge clk)
    begin
        if (!rst_n)
            in_xfer_q <= 1'b0;
        else
        begin
            in_xfer_q <= item_valid && !item_stall;
            if (result_valid && !result_stall)
            begin
                if (repeats_due.size() == 0)
                    note_mismatch("unexpected result, occurrences", occurrences, 0);
                else
                begin
                    due = repeats_due.pop_front();
                    if (occurrences !== due.occ)
                        note_mismatch("occurrences", occurrences, due.occ);
                    if (repeat_len !== due.len)
                        note_mismatch("repeat_len", repeat_len, due.len);
                    if (repeat_start !== due.pos)
                        note_mismatch("repeat_start", repeat_start, due.pos);
                    if (run_end !== due.fin)
                        note_mismatch("run_end", run_end, due.fin);
                end
            end
            if (item_valid && !item_stall)
            begin
                predict_repeats(prefix_len, suffix_start, last_entry);
                items_in <= items_in + 1;
            end
        end
    end

    // driver: bursts of transfers with random gaps, optional wait for drain
    always @(negedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else if (!item_valid || in_xfer_q)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                item_valid <= 1'b0;
            end
            else if (pending_items.size() == 0)
                item_valid <= 1'b0;
            else if (pending_items[0].drain && repeats_due.size() != 0)
                item_valid <= 1'b0;
            else
            begin
                next_item = pending_items.pop_front();
                prefix_len <= next_item.plen;
                suffix_start <= next_item.start;
                last_entry <= next_item.last;
                item_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // receiver stall: rotating patterns plus one long hold-off
    always @(negedge clk)
    begin
        cyc_count <= cyc_count + 1;
        if (!rst_n)
            result_stall <= 1'b0;
        else if (holdoff_left > 0)
        begin
            holdoff_left <= holdoff_left - 1;
            result_stall <= 1'b1;
        end
        else if (!holdoff_done && items_in >= 150)
        begin
            holdoff_done <= 1'b1;
            holdoff_left <= HOLDOFF_CYCLES;
            result_stall <= 1'b1;
        end
        else
        begin
            case (cyc_count[8:7])
                2'd0: result_stall <= 1'b0;
                2'd1: result_stall <= ($urandom_range(0, 3) == 0);
                2'd2: result_stall <= ($urandom_range(0, 9) < 7);
                default: result_stall <= ((cyc_count % 7) < 3);
            endcase
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("lcp_interval_repeat_finder_core test failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int  seq_len;
        int  depth;
        int  pick;
        int  k;
        bit  noisy;
        bit  broken;
        bit  fin;

        // directed: empty stack, saturation, deepest pop, short levels, last entry
        add_entry(0, 0, 0, 0);
        add_entry(127, 20'hFFFFF, 0, 0);
        add_entry(64, 1, 0, 0);
        add_entry(65, 2, 0, 0);
        add_entry(100, 3, 0, 0);
        add_entry(0, 4, 0, 0);
        add_entry(1, 5, 0, 0);
        add_entry(0, 6, 0, 0);
        add_entry(5, 7, 0, 0);
        add_entry(0, 8, 0, 0);
        add_entry(3, 9, 0, 0);
        add_entry(7, 10, 0, 0);
        add_entry(2, 11, 1, 0);
        add_entry(9, 12, 0, 0);
        add_entry(9, 13, 0, 0);
        add_entry(4, 14, 1, 0);
        add_entry(0, 20'h55555, 0, 0);
        add_entry(2, 20'hAAAAA, 0, 0);
        add_entry(0, 0, 1, 0);
        add_entry(127, 20'hFFFFF, 1, 1);
        add_entry(0, 1, 0, 0);

        // random texts: mostly well-formed lcp walks, some noise and unterminated runs
        while (pending_items.size() < ITEM_TARGET)
        begin
            seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(2, 30);
            noisy = ($urandom_range(0, 7) == 0);
            broken = ($urandom_range(0, 9) == 0);
            depth = 0;
            for (k = 0; k < seq_len; k++)
            begin
                if (noisy)
                    depth = $urandom_range(0, 127);
                else if (k == 0)
                    depth = 0;
                else
                begin
                    pick = $urandom_range(0, 11);
                    if (pick < 5)
                        depth = depth + $urandom_range(1, 5);
                    else if (pick < 10)
                        depth = depth - int'($urandom_range(0, depth));
                    else
                        depth = $urandom_range(0, 127);
                    if (depth > 70 && pick < 10)
                        depth = 70;
                end
                fin = noisy ? ($urandom_range(0, 15) == 0) : (k == seq_len - 1 && !broken);
                add_entry(depth, $urandom_range(0, 20'hFFFFF), fin,
                          pending_items.size() == 250);
            end
        end

        // reset
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // wait for all items, then all results, then let the block settle
        while (pending_items.size() != 0 || item_valid)
            @(posedge clk);
        while (repeats_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("lcp_interval_repeat_finder_core test passed");
        else
            $display("lcp_interval_repeat_finder_core test failed");
        $finish;
    end

endmodule

// File: lcp_interval_repeat_finder_core.f
sv/lirf_pkg.sv
sv/lirf_ram.sv
sv/lcp_interval_repeat_finder_core.sv
bench/tb_lcp_interval_repeat_finder_core.sv
